@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ART_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Antecedent in this cycle implies consequent in the next one.
`define ART_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hw/rtl/art_pkg.sv @@
package art_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int MAX_RESULTS   = 16;

    localparam logic [7:0] RESET_INTERVAL = 8'd20;
    localparam logic [3:0] RESET_LIMIT    = 4'd3;

    localparam logic [1:0] CMD_SEND   = 2'd0;
    localparam logic [1:0] CMD_REPLY  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_UNTRACKED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REPLY     = 3'd3;
    localparam logic [2:0] ST_RESEND    = 3'd4;

    localparam logic [15:0] CODE_SHORT_KEY = 16'h0103;
    localparam logic [15:0] CODE_B         = 16'h0205;
    localparam logic [15:0] CODE_C         = 16'h0384;
    localparam logic [15:0] CODE_D         = 16'h0394;
    localparam logic [15:0] CODE_E         = 16'h0330;
    localparam logic [15:0] REPLY_ID_ONLY  = 16'h0104;

    localparam logic [7:0] SHORT_KEY_CHAN = 8'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  frame_type;
        logic [7:0]  frame_command;
        logic [55:0] frame_data;
        logic [7:0]  frame_tag;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] resend_tag;
        logic [3:0] slot;
        logic [4:0] removed_count;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  chan;
        logic [47:0] id;
        logic [7:0]  wait_left;
        logic [3:0]  tries;
        logic [7:0]  tag;
    } entry_t;

    function automatic logic is_tracked(input logic [15:0] code);
        return code == CODE_SHORT_KEY || code == CODE_B || code == CODE_C ||
               code == CODE_D || code == CODE_E;
    endfunction

    function automatic logic is_reply(input logic [15:0] code);
        return code == CODE_SHORT_KEY + 16'd1 || code == CODE_B + 16'd1 ||
               code == CODE_C + 16'd1 || code == CODE_D + 16'd1 ||
               code == CODE_E + 16'd1;
    endfunction

endpackage

@@ hw/rtl/art_cell.sv @@
// One table entry; shifts toward the head or takes a loaded entry.
module art_cell #(
    parameter int SW = 4
) (
    input  logic            clk,
    input  logic            shift,
    input  logic            load,
    input  art_pkg::entry_t load_entry,
    input  logic [SW-1:0]   load_slot,
    input  art_pkg::entry_t nb_entry,
    input  logic [SW-1:0]   nb_slot,
    output art_pkg::entry_t entry,
    output logic [SW-1:0]   slot
);

    art_pkg::entry_t entry_reg;
    logic [SW-1:0]   slot_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= load_entry;
            slot_reg  <= load_slot;
        end
        else if (shift)
        begin
            entry_reg <= nb_entry;
            slot_reg  <= nb_slot;
        end
    end

    assign entry = entry_reg;
    assign slot  = slot_reg;

endmodule

@@ hw/rtl/ack_retransmit_tracker.sv @@
// Pending-reply tracker with timed resends. Entries sit in a chain of cells
// kept in insertion order, oldest at cell 0. Every tracked send, reply or tick walks
// the chain once: each cycle the head cell is examined, the chain shifts one
// cell toward the head and a kept entry goes back in behind the others, and
// a finish state follows the walk. Sends and replies with unknown codes skip
// the walk and return an untracked result; an unused command returns none.
// busy is high during a walk and the finish state; results come at most one per cycle on result,
// marked by done for that cycle only, and the receiver cannot stall them, so
// capture every done cycle. A tick gives one result per resend (last set on
// the final one) and none if nothing is resent. Slot numbers follow the
// lowest free slot rule.
`include "assert_macros.svh"

module ack_retransmit_tracker #(
    parameter int TABLE_DEPTH = art_pkg::DEFAULT_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  art_pkg::req_t request,
    output logic          done,
    output art_pkg::res_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = $clog2(art_pkg::MAX_RESULTS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [NW-1:0] MAX_RES = NW'(art_pkg::MAX_RESULTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PASS = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg;

    // config registers
    logic [7:0] interval_reg;
    logic [3:0] limit_reg;

    // current item
    logic [1:0]  op_reg;
    logic [15:0] key_code_reg;
    logic [7:0]  key_chan_reg;
    logic [47:0] key_id_reg;
    logic        id_only_reg;
    logic [7:0]  key_tag_reg;

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    steps_reg;
    logic [CW-1:0]    removed_reg;
    logic [NW-1:0]    nres_reg;
    logic [TABLE_DEPTH-1:0] used_reg;

    // held resend word, so last can be set on the final one
    logic          pend_v_reg;
    art_pkg::res_t pend_reg;

    logic          done_reg;
    art_pkg::res_t result_reg;

    // chain
    art_pkg::entry_t cell_q    [TABLE_DEPTH];
    logic [SW-1:0]   cell_slot [TABLE_DEPTH];
    art_pkg::entry_t ld_entry;
    logic [SW-1:0]   ld_slot;
    logic [SW-1:0]   wr_idx;
    logic            ld_en;
    logic            shift;

    // head evaluation
    art_pkg::entry_t head_mod;
    logic            keep;
    logic            resend;
    logic            hit;
    logic [SW-1:0]   free_slot;

    logic [15:0] in_code;
    assign in_code = {request.frame_type, request.frame_command};

    assign busy   = (state_reg != S_IDLE);
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {28'd0, limit_reg} : {24'd0, interval_reg};
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        head_mod = cell_q[0];
        keep     = 1'b1;
        resend   = 1'b0;
        hit      = 1'b0;
        unique case (op_reg)
            art_pkg::CMD_SEND:
            begin
                hit  = cell_q[0].code == key_code_reg && cell_q[0].chan == key_chan_reg &&
                       cell_q[0].id == key_id_reg;
                keep = !hit;
            end
            art_pkg::CMD_REPLY:
            begin
                hit  = cell_q[0].code == key_code_reg && cell_q[0].id == key_id_reg &&
                       (id_only_reg || cell_q[0].chan == key_chan_reg);
                keep = !hit;
            end
            art_pkg::CMD_TICK:
            begin
                if (nres_reg == MAX_RES)
                begin
                    keep = 1'b1;
                end
                else if (cell_q[0].wait_left != 8'd0)
                begin
                    head_mod.wait_left = cell_q[0].wait_left - 8'd1;
                end
                else
                begin
                    head_mod.wait_left = interval_reg;
                    if (cell_q[0].tries == 4'd0)
                    begin
                        keep = 1'b0;
                    end
                    else
                    begin
                        head_mod.tries = cell_q[0].tries - 4'd1;
                        resend         = 1'b1;
                    end
                end
            end
            default:
            begin
                keep = 1'b1;
            end
        endcase
    end

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    always_comb
    begin
        shift = (state_reg == S_PASS);
        if (state_reg == S_PASS)
        begin
            ld_en    = keep;
            wr_idx   = SW'(count_reg - CW'(1));
            ld_entry = head_mod;
            ld_slot  = cell_slot[0];
        end
        else
        begin
            ld_en    = (state_reg == S_FIN) && (op_reg == art_pkg::CMD_SEND) &&
                       (count_reg != DEPTH_C);
            wr_idx   = SW'(count_reg);
            ld_entry = '{code: key_code_reg, chan: key_chan_reg, id: key_id_reg,
                         wait_left: 8'd0, tries: limit_reg, tag: key_tag_reg};
            ld_slot  = free_slot;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        art_pkg::entry_t nb_e;
        logic [SW-1:0]   nb_s;
        if (i == TABLE_DEPTH - 1)
        begin : g_end
            assign nb_e = '0;
            assign nb_s = '0;
        end
        else
        begin : g_mid
            assign nb_e = cell_q[i+1];
            assign nb_s = cell_slot[i+1];
        end
        art_cell #(.SW(SW)) u_cell (
            .clk        (clk),
            .shift      (shift),
            .load       (ld_en && wr_idx == SW'(i)),
            .load_entry (ld_entry),
            .load_slot  (ld_slot),
            .nb_entry   (nb_e),
            .nb_slot    (nb_s),
            .entry      (cell_q[i]),
            .slot       (cell_slot[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= art_pkg::RESET_INTERVAL;
            limit_reg    <= art_pkg::RESET_LIMIT;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                limit_reg <= pwdata[3:0];
            else
                interval_reg <= pwdata[7:0];
        end
    end

    // item key, no reset needed
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg       <= request.cmd;
            key_tag_reg  <= request.frame_tag;
            id_only_reg  <= (request.cmd == art_pkg::CMD_REPLY) &&
                            (in_code == art_pkg::REPLY_ID_ONLY);
            if (request.cmd == art_pkg::CMD_SEND)
                key_code_reg <= in_code + 16'd1;
            else
                key_code_reg <= in_code;
            if ((request.cmd == art_pkg::CMD_SEND && in_code == art_pkg::CODE_SHORT_KEY) ||
                (request.cmd == art_pkg::CMD_REPLY && in_code == art_pkg::REPLY_ID_ONLY))
            begin
                key_chan_reg <= art_pkg::SHORT_KEY_CHAN;
                key_id_reg   <= request.frame_data[47:0];
            end
            else
            begin
                key_chan_reg <= request.frame_data[7:0];
                key_id_reg   <= request.frame_data[55:8];
            end
        end
        if (state_reg == S_PASS && resend)
        begin
            pend_reg <= '{status: art_pkg::ST_RESEND, resend_tag: cell_q[0].tag,
                          slot: 4'(cell_slot[0]), removed_count: 5'd0, last: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            steps_reg   <= '0;
            removed_reg <= '0;
            nres_reg    <= '0;
            used_reg    <= '0;
            pend_v_reg  <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        steps_reg   <= count_reg;
                        removed_reg <= '0;
                        nres_reg    <= '0;
                        pend_v_reg  <= 1'b0;
                        if ((request.cmd == art_pkg::CMD_SEND &&
                             !art_pkg::is_tracked(in_code)) ||
                            (request.cmd == art_pkg::CMD_REPLY &&
                             !art_pkg::is_reply(in_code)))
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: art_pkg::ST_UNTRACKED, resend_tag: 8'd0,
                                            slot: 4'd0, removed_count: 5'd0, last: 1'b1};
                        end
                        else if (request.cmd != art_pkg::CMD_UNUSED)
                        begin
                            state_reg <= (count_reg != '0) ? S_PASS : S_FIN;
                        end
                    end
                end
                S_PASS:
                begin
                    if (!keep)
                    begin
                        count_reg              <= count_reg - CW'(1);
                        removed_reg            <= removed_reg + CW'(1);
                        used_reg[cell_slot[0]] <= 1'b0;
                    end
                    if (resend)
                    begin
                        nres_reg   <= nres_reg + NW'(1);
                        pend_v_reg <= 1'b1;
                        if (pend_v_reg)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= pend_reg;
                        end
                    end
                    steps_reg <= steps_reg - CW'(1);
                    if (steps_reg == CW'(1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                    unique case (op_reg)
                        art_pkg::CMD_SEND:
                        begin
                            done_reg <= 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                result_reg <= '{status: art_pkg::ST_FULL, resend_tag: 8'd0,
                                                slot: 4'd0, removed_count: 5'd0, last: 1'b1};
                            end
                            else
                            begin
                                count_reg           <= count_reg + CW'(1);
                                used_reg[free_slot] <= 1'b1;
                                result_reg <= '{status: art_pkg::ST_ACCEPTED, resend_tag: 8'd0,
                                                slot: 4'(free_slot), removed_count: 5'd0,
                                                last: 1'b1};
                            end
                        end
                        art_pkg::CMD_REPLY:
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: art_pkg::ST_REPLY, resend_tag: 8'd0,
                                            slot: 4'd0, removed_count: 5'(removed_reg),
                                            last: 1'b1};
                        end
                        default:
                        begin
                            if (pend_v_reg)
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: pend_reg.status,
                                                resend_tag: pend_reg.resend_tag,
                                                slot: pend_reg.slot,
                                                removed_count: pend_reg.removed_count,
                                                last: 1'b1};
                            end
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ART_ASSERT(a_count_bound, clk, rst_n, count_reg <= DEPTH_C)
    `ART_ASSERT(a_used_matches_count, clk, rst_n, $countones(used_reg) == int'(count_reg))
    `ART_ASSERT(a_pass_has_steps, clk, rst_n, state_reg != S_PASS || steps_reg != '0)
    `ART_ASSERT(a_resend_cap, clk, rst_n, nres_reg <= MAX_RES)
    `ART_ASSERT_NEXT(a_fin_to_idle, clk, rst_n, state_reg == S_FIN, state_reg == S_IDLE)

endmodule

@@ tb/ack_retransmit_tracker_tb.sv @@
`timescale 1ns / 100ps

module ack_retransmit_tracker_tb;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = DEPTH + 8;   // walk of a full chain plus margin
    localparam logic [2:0] ADDR_INTERVAL = 3'd0;   // register byte addresses
    localparam logic [2:0] ADDR_LIMIT    = 3'd4;

    // DUT ports
    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    art_pkg::req_t request;
    logic          done;
    art_pkg::res_t result;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    ack_retransmit_tracker u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Shadow copy of the pending-reply table
    logic [7:0]  cur_interval;
    logic [3:0]  cur_limit;
    bit          tbl_valid [DEPTH];
    logic [15:0] tbl_code  [DEPTH];
    logic [7:0]  tbl_chan  [DEPTH];
    logic [47:0] tbl_id    [DEPTH];
    logic [7:0]  tbl_wait  [DEPTH];
    logic [3:0]  tbl_tries [DEPTH];
    logic [7:0]  tbl_tag   [DEPTH];
    int          tbl_order [DEPTH];
    int          tbl_count;

    art_pkg::res_t pending_results[$];
    int          errors;
    int          mismatches;
    int          cycles;
    int          idle_pct;
    logic [55:0] device_pool[8];

    function automatic bit code_tracked(input logic [15:0] c);
        return c == art_pkg::CODE_SHORT_KEY || c == art_pkg::CODE_B ||
               c == art_pkg::CODE_C || c == art_pkg::CODE_D || c == art_pkg::CODE_E;
    endfunction

    // drop the entry at insertion position pos, keep the chain compact
    task automatic table_drop(input int pos);
        tbl_valid[tbl_order[pos]] = 1'b0;
        for (int i = pos; i + 1 < tbl_count; i++)
            tbl_order[i] = tbl_order[i + 1];
        tbl_count--;
    endtask

    function automatic art_pkg::res_t make_word(input logic [2:0] st, input logic [7:0] tg,
                                                input logic [3:0] sl, input logic [4:0] rm,
                                                input logic lst);
        art_pkg::res_t r;
        r.status        = st;
        r.resend_tag    = tg;
        r.slot          = sl;
        r.removed_count = rm;
        r.last          = lst;
        return r;
    endfunction

    // Work out the words an accepted request produces and update the shadow table
    task automatic predict_tracker(input art_pkg::req_t w);
        logic [15:0]   code;
        logic [15:0]   want;
        logic [7:0]    ch;
        logic [47:0]   id;
        int            pos;
        int            s;
        int            removed;
        bit            hit;
        bit            known;
        art_pkg::res_t burst[$];
        code = {w.frame_type, w.frame_command};
        case (w.cmd)
            art_pkg::CMD_SEND:
            begin
                if (!code_tracked(code))
                begin
                    pending_results.push_back(make_word(art_pkg::ST_UNTRACKED, 8'd0, 4'd0,
                                                        5'd0, 1'b1));
                    return;
                end
                // short-key code carries no channel byte
                if (code == art_pkg::CODE_SHORT_KEY)
                begin
                    ch = art_pkg::SHORT_KEY_CHAN;
                    id = w.frame_data[47:0];
                end
                else
                begin
                    ch = w.frame_data[7:0];
                    id = w.frame_data[55:8];
                end
                want = code + 16'd1;
                pos = 0;
                while (pos < tbl_count)
                begin
                    s = tbl_order[pos];
                    if (tbl_code[s] == want && tbl_chan[s] == ch && tbl_id[s] == id)
                        table_drop(pos);
                    else
                        pos++;
                end
                if (tbl_count >= DEPTH)
                begin
                    pending_results.push_back(make_word(art_pkg::ST_FULL, 8'd0, 4'd0,
                                                        5'd0, 1'b1));
                    return;
                end
                // lowest free slot
                for (s = 0; s < DEPTH; s++)
                    if (!tbl_valid[s])
                        break;
                tbl_valid[s] = 1'b1;
                tbl_code[s]  = want;
                tbl_chan[s]  = ch;
                tbl_id[s]    = id;
                tbl_wait[s]  = 8'd0;
                tbl_tries[s] = cur_limit;
                tbl_tag[s]   = w.frame_tag;
                tbl_order[tbl_count] = s;
                tbl_count++;
                pending_results.push_back(make_word(art_pkg::ST_ACCEPTED, 8'd0, s[3:0],
                                                    5'd0, 1'b1));
            end
            art_pkg::CMD_REPLY:
            begin
                known = code_tracked(code - 16'd1);
                if (!known)
                begin
                    pending_results.push_back(make_word(art_pkg::ST_UNTRACKED, 8'd0, 4'd0,
                                                        5'd0, 1'b1));
                    return;
                end
                removed = 0;
                pos = 0;
                while (pos < tbl_count)
                begin
                    s = tbl_order[pos];
                    hit = 1'b0;
                    if (tbl_code[s] == code)
                    begin
                        if (code == art_pkg::REPLY_ID_ONLY)
                            hit = tbl_id[s] == w.frame_data[47:0];
                        else
                            hit = tbl_chan[s] == w.frame_data[7:0] &&
                                  tbl_id[s] == w.frame_data[55:8];
                    end
                    if (hit)
                    begin
                        table_drop(pos);
                        removed++;
                    end
                    else
                        pos++;
                end
                pending_results.push_back(make_word(art_pkg::ST_REPLY, 8'd0, 4'd0,
                                                    removed[4:0], 1'b1));
            end
            art_pkg::CMD_TICK:
            begin
                pos = 0;
                while (pos < tbl_count && burst.size() < art_pkg::MAX_RESULTS)
                begin
                    s = tbl_order[pos];
                    if (tbl_wait[s] != 8'd0)
                    begin
                        tbl_wait[s]--;
                        pos++;
                        continue;
                    end
                    tbl_wait[s] = cur_interval;
                    if (tbl_tries[s] == 4'd0)
                    begin
                        table_drop(pos);
                        continue;
                    end
                    tbl_tries[s]--;
                    burst.push_back(make_word(art_pkg::ST_RESEND, tbl_tag[s], s[3:0],
                                              5'd0, 1'b0));
                    pos++;
                end
                // last marks the final resend of this tick
                if (burst.size() > 0)
                    burst[burst.size() - 1].last = 1'b1;
                foreach (burst[i])
                    pending_results.push_back(burst[i]);
            end
            default:
            begin
                // unused command: no word, no state change
            end
        endcase
    endtask

    // Hand one request to the DUT; start stays high so back-to-back
    // requests need no extra nonblocking update in the accept step.
    task automatic send_request(input art_pkg::req_t w);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        predict_tracker(w);
    endtask

    // Wait until every expected word is in and the walk has surely ended
    task automatic drain_tracker;
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup then access; only called with the DUT idle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_INTERVAL)
            cur_interval = data[7:0];
        else
            cur_limit = data[3:0];
    endtask

    task automatic set_timing(input logic [7:0] interval, input logic [3:0] limit);
        write_reg(ADDR_INTERVAL, {24'd0, interval});
        write_reg(ADDR_LIMIT, {28'd0, limit});
    endtask

    function automatic art_pkg::req_t build_req(input logic [1:0] c, input logic [15:0] code,
                                                input logic [55:0] data, input logic [7:0] tg);
        art_pkg::req_t w;
        w.cmd           = c;
        w.frame_type    = code[15:8];
        w.frame_command = code[7:0];
        w.frame_data    = data;
        w.frame_tag     = tg;
        return w;
    endfunction

    function automatic logic [55:0] rand_data();
        return 56'({$urandom, $urandom});
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(4))
            0: return art_pkg::CODE_SHORT_KEY;
            1: return art_pkg::CODE_B;
            2: return art_pkg::CODE_C;
            3: return art_pkg::CODE_D;
            default: return art_pkg::CODE_E;
        endcase
    endfunction

    // Every code, both key forms, replace, replies of both kinds, unused command
    task automatic test_directed_codes;
        logic [55:0] ones;
        ones = {56{1'b1}};
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_SHORT_KEY, ones, 8'hFF));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_B, 56'd0, 8'h00));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_C, 56'h11_2233_4455_6677,
                               8'h5A));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_D, ones, 8'hA5));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_E, 56'h01_0203_0405_0607,
                               8'h3C));
        // same code and key again: older entry replaced
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_C, 56'h11_2233_4455_6677,
                               8'h77));
        send_request(build_req(art_pkg::CMD_SEND, 16'hFFFF, ones, 8'h01));
        send_request(build_req(art_pkg::CMD_SEND, 16'h0000, 56'd0, 8'h02));
        send_request(build_req(art_pkg::CMD_TICK, 16'd0, 56'd0, 8'd0));
        send_request(build_req(art_pkg::CMD_TICK, 16'd0, 56'd0, 8'd0));
        // id-only reply ignores byte 6
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::REPLY_ID_ONLY,
                               {8'h00, ones[47:0]}, 8'd0));
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_B + 16'd1, 56'd0, 8'd0));
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_C + 16'd1,
                               56'h11_2233_4455_6677, 8'd0));
        // no match
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_D + 16'd1, 56'd1, 8'd0));
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_D + 16'd1, ones, 8'd0));
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_E + 16'd1,
                               56'h01_0203_0405_0607, 8'd0));
        // unknown reply
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_B, 56'd0, 8'd0));
        // unused command
        send_request(build_req(art_pkg::CMD_UNUSED, 16'hFFFF, ones, 8'hFF));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_B, ones, 8'h81));
        for (int i = 0; i < 5; i++)
            send_request(build_req(art_pkg::CMD_TICK, 16'd0, 56'd0, 8'd0));
    endtask

    // Seventeen distinct keys against a sixteen-deep table
    task automatic test_table_full;
        for (int i = 0; i < DEPTH + 1; i++)
            send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_E,
                                   {48'h00C0_FFEE_0000, i[7:0]}, i[7:0]));
        send_request(build_req(art_pkg::CMD_TICK, 16'd0, 56'd0, 8'd0));
        send_request(build_req(art_pkg::CMD_REPLY, art_pkg::CODE_E + 16'd1,
                               {48'h00C0_FFEE_0000, 8'd3}, 8'd0));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_E,
                               {48'h00C0_FFEE_0000, 8'd40}, 8'd40));
        send_request(build_req(art_pkg::CMD_SEND, art_pkg::CODE_E,
                               {48'h00C0_FFEE_0000, 8'd41}, 8'd41));
    endtask

    // Mostly well-formed traffic over a small device pool so replies hit
    task automatic test_random_traffic(input int count);
        logic [15:0] code;
        logic [55:0] data;
        int          r;
        for (int n = 0; n < count; n++)
        begin
            r    = $urandom_range(99);
            code = pick_code();
            data = device_pool[$urandom_range(7)];
            if (r < 35)
                send_request(build_req(art_pkg::CMD_SEND, code, data, 8'($urandom)));
            else if (r < 55)
                send_request(build_req(art_pkg::CMD_REPLY, code + 16'd1, data,
                                       8'($urandom)));
            else if (r < 85)
                send_request(build_req(art_pkg::CMD_TICK, 16'($urandom), rand_data(),
                                       8'($urandom)));
            else if (r < 95)
                send_request(build_req(2'($urandom), 16'($urandom), rand_data(),
                                       8'($urandom)));
            else
                send_request(build_req(art_pkg::CMD_SEND, 16'($urandom), rand_data(),
                                       8'($urandom)));
        end
    endtask

    // Result checker: the DUT cannot be stalled, so every done cycle counts
    always @(posedge clk)
    begin
        art_pkg::res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d tag %0h slot %0d removed %0d last %0d",
                             result.status, result.resend_tag, result.slot,
                             result.removed_count, result.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status || result.resend_tag !== want.resend_tag ||
                    result.slot !== want.slot || result.removed_count !== want.removed_count ||
                    result.last !== want.last)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st %0d tag %0h slot %0d rm %0d last %0d,",
                                  " got st %0d tag %0h slot %0d rm %0d last %0d"},
                                 want.status, want.resend_tag, want.slot, want.removed_count,
                                 want.last, result.status, result.resend_tag, result.slot,
                                 result.removed_count, result.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        request  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors     = 0;
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 12;
        cur_interval = art_pkg::RESET_INTERVAL;
        cur_limit    = art_pkg::RESET_LIMIT;
        tbl_count    = 0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 1'b0;
        foreach (device_pool[i])
            device_pool[i] = rand_data();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_codes();
        drain_tracker();               // sender holds off until all words are in

        set_timing(8'd0, 4'd0);         // no resends, drop on the first tick
        test_random_traffic(110);
        drain_tracker();

        set_timing(8'd255, 4'd15);      // long waits, table fills
        test_table_full();
        idle_pct = 80;
        test_random_traffic(60);
        drain_tracker();

        set_timing(8'd2, 4'd3);
        test_random_traffic(60);
        drain_tracker();

        idle_pct = 0;
        set_timing(8'd1, 4'd15);
        test_random_traffic(80);
        drain_tracker();

        errors += pending_results.size();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
